// File: hdl/sbd_pkg.sv
// Shared constants, register codes and lookup-table builders for the split-band de-esser.
package sbd_pkg;

   localparam int OP_W       = 33;
   localparam int PROD_W     = 66;
   localparam int TAB_MAX_BITS = 12;
   localparam int TAB_MAX    = 1 << TAB_MAX_BITS;

   localparam int LOG_TABLE_BITS_DEF = 8;
   localparam int EXP_TABLE_BITS_DEF = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_LOW_B0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_B0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POLE_A1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POLE_A2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RATIO     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE   = 3'd7;

   localparam logic signed [23:0] RST_LOW_B0    = 24'sd409500;
   localparam logic signed [23:0] RST_HIGH_B0   = 24'sd2386800;
   localparam logic signed [23:0] RST_POLE_A1   = -24'sd3954500;
   localparam logic signed [23:0] RST_POLE_A2   = 24'sd1398101;
   localparam logic signed [15:0] RST_THRESHOLD = -16'sd5120;
   localparam logic [15:0]        RST_RATIO     = 16'd32768;
   localparam logic [23:0]        RST_ATTACK    = 24'd15000000;
   localparam logic [23:0]        RST_RELEASE   = 24'd16700000;

   localparam logic signed [16:0] DB_FLOOR      = -17'sd51200;
   localparam logic signed [19:0] DB_PER_OCT    = 20'sd394566;
   localparam logic signed [15:0] OCT_PER_UNIT  = 16'sd21771;
   localparam logic signed [16:0] REDUCE_LIMIT  = -17'sd128;

   typedef logic [15:0] log_tab_type [TAB_MAX];
   typedef logic [30:0] exp_tab_type [TAB_MAX];

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bt;
      int j;
      v = v_in;
      res = 64'd0;
      bt = 64'd1 << 62;
      for (j = 0; j < 32; j++) begin
         if (bt > v) bt = bt >> 2;
      end
      for (j = 0; j < 32; j++) begin
         if (bt != 64'd0) begin
            if (v >= res + bt) begin
               v = v - (res + bt);
               res = (res >> 1) + bt;
            end else begin
               res = res >> 1;
            end
            bt = bt >> 2;
         end
      end
      return res;
   endfunction

   // log2(1 + i/2^bits) in Q16 by repeated squaring
   function automatic log_tab_type build_log_tab(input int bits);
      log_tab_type tab;
      logic [63:0] m;
      logic [15:0] r;
      int i;
      int k;
      for (i = 0; i < TAB_MAX; i++) begin
         tab[i] = 16'd0;
         if (i < (1 << bits)) begin
            m = (64'(1 << bits) + 64'(i)) << (30 - bits);
            r = 16'd0;
            for (k = 0; k < 16; k++) begin
               m = (m * m) >> 30;
               if (m >= (64'd2 << 30)) begin
                  m = m >> 1;
                  r[15-k] = 1'b1;
               end
            end
            tab[i] = r;
         end
      end
      return tab;
   endfunction

   // 2^(i/2^bits) in Q30 as a product of nested square roots of two
   function automatic exp_tab_type build_exp_tab(input int bits);
      exp_tab_type tab;
      logic [63:0] roots [TAB_MAX_BITS+1];
      logic [63:0] m;
      int i;
      int k;
      for (k = 0; k <= TAB_MAX_BITS; k++) roots[k] = 64'd0;
      roots[0] = 64'd2 << 30;
      for (k = 1; k <= bits; k++) roots[k] = isqrt64(roots[k-1] << 30);
      for (i = 0; i < TAB_MAX; i++) begin
         tab[i] = 31'd0;
         if (i < (1 << bits)) begin
            m = 64'd1 << 30;
            for (k = 1; k <= bits; k++) begin
               if (((i >> (bits - k)) & 1) != 0) m = (m * roots[k]) >> 30;
            end
            tab[i] = m[30:0];
         end
      end
      return tab;
   endfunction

endpackage

// File: hdl/sbd_mac.sv
// Shared signed multiplier with a registered product.
module sbd_mac (
   input  logic                                  clock,
   input  logic                                  load,
   input  logic signed [sbd_pkg::OP_W-1:0]       op_a,
   input  logic signed [sbd_pkg::OP_W-1:0]       op_b,
   output logic signed [sbd_pkg::PROD_W-1:0]     prod
);

   logic signed [sbd_pkg::PROD_W-1:0] prod_ff;
   logic signed [sbd_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (load) prod_in = sbd_pkg::PROD_W'(op_a) * sbd_pkg::PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: hdl/split_band_deesser_core.sv
// Split-band de-esser: one mono sample in, one processed sample with level and gain out.
// One sample is processed at a time; a new one is taken only when the last has finished.
// A small step sequencer drives one 33x33 signed multiplier with a registered product
// through fourteen products (six for the two biquads, two each for the envelope and gain
// smoothers, one each for the dB conversion, gain computer, exp2 step and final scaling),
// each product taking an issue step and an accumulate step, plus three preparation steps
// and one idle step in which the next sample is taken.
// req_stall is high while a sample is in flight; a finished result waits in the output
// register, so the next sample is taken while it is still unread, but the sequencer holds
// at its last step until that result is read. Configuration goes in through the csr_ port,
// always ready; the user must write it only while no sample is in flight (not enforced).
module split_band_deesser_core #(
   parameter int LOG_TABLE_BITS = sbd_pkg::LOG_TABLE_BITS_DEF,
   parameter int EXP_TABLE_BITS = sbd_pkg::EXP_TABLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [23:0]                  req_audio_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [23:0]                  rsp_audio_out,
   output logic signed [16:0]                  rsp_env_db,
   output logic signed [16:0]                  rsp_gain_db,
   output logic                                rsp_reducing,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int OPW = sbd_pkg::OP_W;
   localparam int PW  = sbd_pkg::PROD_W;
   localparam int TIW = sbd_pkg::TAB_MAX_BITS;

   localparam sbd_pkg::log_tab_type LOG_TAB = sbd_pkg::build_log_tab(LOG_TABLE_BITS);
   localparam sbd_pkg::exp_tab_type EXP_TAB = sbd_pkg::build_exp_tab(EXP_TABLE_BITS);

   localparam logic signed [PW-1:0] RND_15 = 66'sd32768;
   localparam logic signed [PW-1:0] RND_21 = 66'sd2097152;
   localparam logic signed [PW-1:0] RND_23 = 66'sd8388608;
   localparam logic signed [PW-1:0] RND_29 = 66'sd536870912;
   localparam logic signed [PW-1:0] MAX_32 = 66'sd2147483647;
   localparam logic signed [PW-1:0] MIN_32 = -66'sd2147483648;
   localparam logic signed [33:0]   MAX_24 = 34'sd8388607;
   localparam logic signed [33:0]   MIN_24 = -34'sd8388608;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_LO_M0    = 5'd1;
   localparam logic [4:0] S_LO_A0    = 5'd2;
   localparam logic [4:0] S_LO_M1    = 5'd3;
   localparam logic [4:0] S_LO_A1    = 5'd4;
   localparam logic [4:0] S_LO_M2    = 5'd5;
   localparam logic [4:0] S_LO_A2    = 5'd6;
   localparam logic [4:0] S_HI_M0    = 5'd7;
   localparam logic [4:0] S_HI_A0    = 5'd8;
   localparam logic [4:0] S_HI_M1    = 5'd9;
   localparam logic [4:0] S_HI_A1    = 5'd10;
   localparam logic [4:0] S_HI_M2    = 5'd11;
   localparam logic [4:0] S_HI_A2    = 5'd12;
   localparam logic [4:0] S_ENV_PREP = 5'd13;
   localparam logic [4:0] S_ENV_M0   = 5'd14;
   localparam logic [4:0] S_ENV_A0   = 5'd15;
   localparam logic [4:0] S_ENV_M1   = 5'd16;
   localparam logic [4:0] S_ENV_A1   = 5'd17;
   localparam logic [4:0] S_LOG_PREP = 5'd18;
   localparam logic [4:0] S_DB_M     = 5'd19;
   localparam logic [4:0] S_DB_A     = 5'd20;
   localparam logic [4:0] S_GC_M     = 5'd21;
   localparam logic [4:0] S_GC_A     = 5'd22;
   localparam logic [4:0] S_SM_PREP  = 5'd23;
   localparam logic [4:0] S_SM_M0    = 5'd24;
   localparam logic [4:0] S_SM_A0    = 5'd25;
   localparam logic [4:0] S_SM_M1    = 5'd26;
   localparam logic [4:0] S_SM_A1    = 5'd27;
   localparam logic [4:0] S_EXP_M    = 5'd28;
   localparam logic [4:0] S_EXP_A    = 5'd29;
   localparam logic [4:0] S_OUT_M    = 5'd30;
   localparam logic [4:0] S_OUT_A    = 5'd31;

   function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] q);
      logic signed [31:0] r;
      r = q[31:0];
      if (q > MAX_32) r = 32'sh7FFFFFFF;
      else if (q < MIN_32) r = 32'sh80000000;
      return r;
   endfunction

   // configuration
   logic signed [23:0] low_b0_ff, low_b0_in, high_b0_ff, high_b0_in;
   logic signed [23:0] pole_a1_ff, pole_a1_in, pole_a2_ff, pole_a2_in;
   logic signed [15:0] thr_ff, thr_in;
   logic [15:0]        slope_ff, slope_in;
   logic [23:0]        atk_ff, atk_in, rel_ff, rel_in;

   // state
   logic [4:0]         step_ff, step_in;
   logic signed [23:0] x_ff, x_in;
   logic signed [23:0] lx1_ff, lx1_in, lx2_ff, lx2_in, hx1_ff, hx1_in, hx2_ff, hx2_in;
   logic signed [31:0] ly1_ff, ly1_in, ly2_ff, ly2_in, hy1_ff, hy1_in, hy2_ff, hy2_in;
   logic [31:0]        env_ff, env_in;
   logic signed [23:0] gain_ff, gain_in;

   // work registers
   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [31:0]   lo_ff, lo_in, hp_ff, hp_in;
   logic [31:0]          mag_ff, mag_in;
   logic [23:0]          coef_ff, coef_in;
   logic signed [21:0]   lvl_ff, lvl_in;
   logic                 envzero_ff, envzero_in;
   logic signed [16:0]   edb_ff, edb_in;
   logic signed [16:0]   target_ff, target_in;
   logic [30:0]          lin_ff, lin_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [23:0]   out_audio_ff, out_audio_in;
   logic signed [16:0]   out_env_ff, out_env_in;
   logic signed [16:0]   out_gain_ff, out_gain_in;
   logic                 out_red_ff, out_red_in;

   logic                 mac_load;
   logic signed [OPW-1:0] mul_a, mul_b;
   logic signed [PW-1:0]  prod;

   logic signed [25:0]   sum_lo, sum_hi;
   logic [24:0]          coef_comp;
   logic signed [PW-1:0] acc_sub, acc_add;
   logic signed [32:0]   hp_wide, mag_wide;
   logic [4:0]           msb_pos;
   logic [31:0]          norm;
   logic [LOG_TABLE_BITS-1:0] log_idx;
   logic [5:0]           oct;
   logic signed [17:0]   db_diff;
   logic signed [PW-1:0] gc_q;
   logic signed [PW-1:0] gc_neg;
   logic signed [23:0]   t_val;
   logic signed [PW-1:0] exp_q;
   logic signed [23:0]   e_val;
   logic signed [7:0]    e_ip;
   logic [7:0]           e_shift;
   logic [EXP_TABLE_BITS-1:0] exp_idx;
   logic [30:0]          exp_ent;
   logic signed [PW-1:0] out_q;
   logic signed [33:0]   out_sum;
   logic signed [24:0]   gdb_sum;
   logic                 in_beat, out_beat, fire;

   assign in_beat  = req_valid && !req_stall;
   assign out_beat = rsp_valid_ff && !rsp_stall;
   assign fire     = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (step_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign sum_lo = 26'(x_ff) + (26'(lx1_ff) <<< 1) + 26'(lx2_ff);
   assign sum_hi = 26'(x_ff) - (26'(hx1_ff) <<< 1) + 26'(hx2_ff);
   assign coef_comp = 25'h1000000 - {1'b0, coef_ff};
   assign acc_sub = acc_ff - prod;
   assign acc_add = acc_ff + prod;

   assign hp_wide  = 33'(hp_ff);
   assign mag_wide = hp_ff[31] ? -hp_wide : hp_wide;

   always_comb begin
      msb_pos = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (env_ff[i]) msb_pos = 5'(i);
      end
   end
   assign norm    = env_ff << (5'd31 - msb_pos);
   assign log_idx = norm[30 -: LOG_TABLE_BITS];
   assign oct     = 6'(msb_pos) - 6'd23;

   assign db_diff = 18'(edb_ff) - 18'(thr_ff);
   assign gc_q    = (prod + RND_15) >>> 16;
   assign gc_neg  = -gc_q;
   assign t_val   = {target_ff, 7'b0};

   assign exp_q   = (prod + RND_15) >>> 16;
   assign e_val   = exp_q[23:0];
   assign e_ip    = e_val[23:16];
   assign e_shift = e_ip[7] ? 8'(-e_ip) : 8'd0;
   assign exp_idx = e_val[15 -: EXP_TABLE_BITS];
   assign exp_ent = EXP_TAB[TIW'(exp_idx)];

   assign out_q   = (prod + RND_29) >>> 30;
   assign out_sum = 34'(lo_ff) + out_q[33:0];
   assign gdb_sum = (25'(gain_ff) + 25'sd64) >>> 7;

   // operand select for the shared multiplier
   always_comb begin
      mac_load = 1'b1;
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         S_LO_M0: begin mul_a = OPW'(low_b0_ff);  mul_b = OPW'(sum_lo); end
         S_LO_M1: begin mul_a = OPW'(pole_a1_ff); mul_b = OPW'(ly1_ff); end
         S_LO_M2: begin mul_a = OPW'(pole_a2_ff); mul_b = OPW'(ly2_ff); end
         S_HI_M0: begin mul_a = OPW'(high_b0_ff); mul_b = OPW'(sum_hi); end
         S_HI_M1: begin mul_a = OPW'(pole_a1_ff); mul_b = OPW'(hy1_ff); end
         S_HI_M2: begin mul_a = OPW'(pole_a2_ff); mul_b = OPW'(hy2_ff); end
         S_ENV_M0: begin mul_a = OPW'(coef_ff);   mul_b = OPW'(env_ff); end
         S_ENV_M1: begin mul_a = OPW'(coef_comp); mul_b = OPW'(mag_ff); end
         S_DB_M: begin mul_a = OPW'(lvl_ff); mul_b = OPW'(sbd_pkg::DB_PER_OCT); end
         S_GC_M: begin mul_a = OPW'(db_diff); mul_b = OPW'(slope_ff); end
         S_SM_M0: begin mul_a = OPW'(coef_ff);   mul_b = OPW'(gain_ff); end
         S_SM_M1: begin mul_a = OPW'(coef_comp); mul_b = OPW'(t_val); end
         S_EXP_M: begin mul_a = OPW'(gain_ff); mul_b = OPW'(sbd_pkg::OCT_PER_UNIT); end
         S_OUT_M: begin mul_a = OPW'(hp_ff); mul_b = OPW'(lin_ff); end
         default: mac_load = 1'b0;
      endcase
   end

   sbd_mac u_mac (
      .clock (clock),
      .load  (mac_load),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   always_comb begin
      low_b0_in  = low_b0_ff;
      high_b0_in = high_b0_ff;
      pole_a1_in = pole_a1_ff;
      pole_a2_in = pole_a2_ff;
      thr_in     = thr_ff;
      slope_in   = slope_ff;
      atk_in     = atk_ff;
      rel_in     = rel_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sbd_pkg::REG_LOW_B0:    low_b0_in  = csr_wdata;
            sbd_pkg::REG_HIGH_B0:   high_b0_in = csr_wdata;
            sbd_pkg::REG_POLE_A1:   pole_a1_in = csr_wdata;
            sbd_pkg::REG_POLE_A2:   pole_a2_in = csr_wdata;
            sbd_pkg::REG_THRESHOLD: thr_in     = csr_wdata[15:0];
            sbd_pkg::REG_RATIO:     slope_in   = csr_wdata[15:0];
            sbd_pkg::REG_ATTACK:    atk_in     = csr_wdata;
            sbd_pkg::REG_RELEASE:   rel_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      step_in    = step_ff;
      x_in       = x_ff;
      lx1_in = lx1_ff; lx2_in = lx2_ff; hx1_in = hx1_ff; hx2_in = hx2_ff;
      ly1_in = ly1_ff; ly2_in = ly2_ff; hy1_in = hy1_ff; hy2_in = hy2_ff;
      env_in     = env_ff;
      gain_in    = gain_ff;
      acc_in     = acc_ff;
      lo_in      = lo_ff;
      hp_in      = hp_ff;
      mag_in     = mag_ff;
      coef_in    = coef_ff;
      lvl_in     = lvl_ff;
      envzero_in = envzero_ff;
      edb_in     = edb_ff;
      target_in  = target_ff;
      lin_in     = lin_ff;
      rsp_valid_in = rsp_valid_ff && !out_beat;
      out_audio_in = out_audio_ff;
      out_env_in   = out_env_ff;
      out_gain_in  = out_gain_ff;
      out_red_in   = out_red_ff;

      if (step_ff != S_IDLE && step_ff != S_OUT_A) step_in = step_ff + 5'd1;

      unique case (step_ff)
         S_IDLE: begin
            if (in_beat) begin
               x_in = req_audio_in;
               step_in = S_LO_M0;
            end
         end
         S_LO_A0, S_HI_A0, S_ENV_A0, S_SM_A0: acc_in = prod;
         S_LO_A1, S_HI_A1: acc_in = acc_sub;
         S_LO_A2: begin
            lo_in  = sat32((acc_sub + RND_21) >>> 22);
            ly2_in = ly1_ff;
            ly1_in = sat32((acc_sub + RND_21) >>> 22);
            lx2_in = lx1_ff;
            lx1_in = x_ff;
         end
         S_HI_A2: begin
            hp_in  = sat32((acc_sub + RND_21) >>> 22);
            hy2_in = hy1_ff;
            hy1_in = sat32((acc_sub + RND_21) >>> 22);
            hx2_in = hx1_ff;
            hx1_in = x_ff;
         end
         S_ENV_PREP: begin
            mag_in  = mag_wide[31:0];
            coef_in = (mag_wide[31:0] > env_ff) ? atk_ff : rel_ff;
         end
         S_ENV_A1: begin
            acc_in = (acc_add + RND_23) >>> 24;
            env_in = acc_in[31:0];
         end
         S_LOG_PREP: begin
            envzero_in = (env_ff == 32'd0);
            lvl_in = {oct, LOG_TAB[TIW'(log_idx)]};
         end
         S_DB_A: begin
            acc_in = (prod + RND_23) >>> 24;
            edb_in = envzero_ff ? sbd_pkg::DB_FLOOR : acc_in[16:0];
         end
         S_GC_A: begin
            target_in = (edb_ff > 17'(thr_ff)) ? gc_neg[16:0] : 17'sd0;
         end
         S_SM_PREP: begin
            coef_in = (t_val < gain_ff) ? atk_ff : rel_ff;
         end
         S_SM_A1: begin
            acc_in  = (acc_add + RND_23) >>> 24;
            gain_in = acc_in[23:0];
         end
         S_EXP_A: begin
            // drop the gain entirely once the shift reaches 40 octaves
            lin_in = (e_shift >= 8'd40) ? 31'd0 : (exp_ent >> e_shift);
         end
         S_OUT_A: begin
            if (fire) begin
               step_in = S_IDLE;
               rsp_valid_in = 1'b1;
               if (out_sum > MAX_24) out_audio_in = 24'sh7FFFFF;
               else if (out_sum < MIN_24) out_audio_in = 24'sh800000;
               else out_audio_in = out_sum[23:0];
               out_env_in  = edb_ff;
               out_gain_in = gdb_sum[16:0];
               out_red_in  = (target_ff < sbd_pkg::REDUCE_LIMIT);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_b0_ff  <= sbd_pkg::RST_LOW_B0;
         high_b0_ff <= sbd_pkg::RST_HIGH_B0;
         pole_a1_ff <= sbd_pkg::RST_POLE_A1;
         pole_a2_ff <= sbd_pkg::RST_POLE_A2;
         thr_ff     <= sbd_pkg::RST_THRESHOLD;
         slope_ff   <= sbd_pkg::RST_RATIO;
         atk_ff     <= sbd_pkg::RST_ATTACK;
         rel_ff     <= sbd_pkg::RST_RELEASE;
         step_ff    <= S_IDLE;
         lx1_ff <= '0; lx2_ff <= '0; hx1_ff <= '0; hx2_ff <= '0;
         ly1_ff <= '0; ly2_ff <= '0; hy1_ff <= '0; hy2_ff <= '0;
         env_ff     <= '0;
         gain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_b0_ff  <= low_b0_in;
         high_b0_ff <= high_b0_in;
         pole_a1_ff <= pole_a1_in;
         pole_a2_ff <= pole_a2_in;
         thr_ff     <= thr_in;
         slope_ff   <= slope_in;
         atk_ff     <= atk_in;
         rel_ff     <= rel_in;
         step_ff    <= step_in;
         lx1_ff <= lx1_in; lx2_ff <= lx2_in; hx1_ff <= hx1_in; hx2_ff <= hx2_in;
         ly1_ff <= ly1_in; ly2_ff <= ly2_in; hy1_ff <= hy1_in; hy2_ff <= hy2_in;
         env_ff     <= env_in;
         gain_ff    <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      acc_ff     <= acc_in;
      lo_ff      <= lo_in;
      hp_ff      <= hp_in;
      mag_ff     <= mag_in;
      coef_ff    <= coef_in;
      lvl_ff     <= lvl_in;
      envzero_ff <= envzero_in;
      edb_ff     <= edb_in;
      target_ff  <= target_in;
      lin_ff     <= lin_in;
      out_audio_ff <= out_audio_in;
      out_env_ff   <= out_env_in;
      out_gain_ff  <= out_gain_in;
      out_red_ff   <= out_red_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_audio_out = out_audio_ff;
   assign rsp_env_db    = out_env_ff;
   assign rsp_gain_db   = out_gain_ff;
   assign rsp_reducing  = out_red_ff;

endmodule

// File: dv/tb_split_band_deesser_core.sv
// Self-checking testbench for the split-band de-esser core with a built-in predictor.
`timescale 1ns / 100ps

module tb_split_band_deesser_core;

   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_ITEMS = 120;

   typedef struct {
      bit          is_cfg;
      logic [2:0]  idx;
      logic [23:0] data;
   } stim_op_type;

   typedef struct {
      logic signed [23:0] audio;
      logic signed [16:0] env_db;
      logic signed [16:0] gain_db;
      logic               reducing;
   } deess_result_type;

   logic clock;
   logic reset;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_audio_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_audio_out;
   logic signed [16:0] rsp_env_db;
   logic signed [16:0] rsp_gain_db;
   logic rsp_reducing;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sbd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sbd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   split_band_deesser_core u_top (.*);

   stim_op_type      stim_q[$];
   deess_result_type result_q[$];

   // predictor configuration and state
   longint cfg_low_b0, cfg_high_b0, cfg_a1, cfg_a2, cfg_thr, cfg_ratio, cfg_atk, cfg_rel;
   longint bq_x[2][2];
   longint bq_y[2][2];
   longint envelope;
   longint smooth_gain;
   longint unsigned log_lut[256];
   longint unsigned exp_lut[256];

   int err_count = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int cfg_writes = 0;
   int gap_left = 0;
   int stall_left = 0;
   int idle_since = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic longint sat_w(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v_in);
      longint unsigned v, res, bt;
      v = v_in;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   initial begin
      longint unsigned m;
      longint unsigned roots[9];
      logic [15:0] r;
      for (int i = 0; i < 256; i++) begin
         m = longint'(256 + i) << 22;
         r = '0;
         for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
               m = m >> 1;
               r[15-k] = 1'b1;
            end
         end
         log_lut[i] = 64'(r);
      end
      roots[0] = 64'd2 << 30;
      for (int k = 1; k <= 8; k++) roots[k] = int_sqrt(roots[k-1] << 30);
      for (int i = 0; i < 256; i++) begin
         m = 64'd1 << 30;
         for (int k = 1; k <= 8; k++)
            if ((i >> (8 - k)) & 1) m = (m * roots[k]) >> 30;
         exp_lut[i] = m;
      end
   end

   task automatic restore_defaults();
      cfg_low_b0 = sbd_pkg::RST_LOW_B0;
      cfg_high_b0 = sbd_pkg::RST_HIGH_B0;
      cfg_a1 = sbd_pkg::RST_POLE_A1;
      cfg_a2 = sbd_pkg::RST_POLE_A2;
      cfg_thr = sbd_pkg::RST_THRESHOLD;
      cfg_ratio = sbd_pkg::RST_RATIO;
      cfg_atk = sbd_pkg::RST_ATTACK;
      cfg_rel = sbd_pkg::RST_RELEASE;
      for (int b = 0; b < 2; b++)
         for (int j = 0; j < 2; j++) begin
            bq_x[b][j] = 0;
            bq_y[b][j] = 0;
         end
      envelope = 0;
      smooth_gain = 0;
   endtask

   task automatic apply_cfg(logic [2:0] idx, logic [23:0] d);
      case (idx)
         sbd_pkg::REG_LOW_B0:    cfg_low_b0 = longint'($signed(d));
         sbd_pkg::REG_HIGH_B0:   cfg_high_b0 = longint'($signed(d));
         sbd_pkg::REG_POLE_A1:   cfg_a1 = longint'($signed(d));
         sbd_pkg::REG_POLE_A2:   cfg_a2 = longint'($signed(d));
         sbd_pkg::REG_THRESHOLD: cfg_thr = longint'($signed(d[15:0]));
         sbd_pkg::REG_RATIO:     cfg_ratio = longint'(d[15:0]);
         sbd_pkg::REG_ATTACK:    cfg_atk = longint'(d);
         sbd_pkg::REG_RELEASE:   cfg_rel = longint'(d);
         default: ;
      endcase
   endtask

   function automatic longint biquad(int b, longint b0, longint b1, longint x);
      longint acc, y;
      acc = b0 * x + b1 * bq_x[b][0] + b0 * bq_x[b][1] - cfg_a1 * bq_y[b][0]
            - cfg_a2 * bq_y[b][1];
      y = sat_w((acc + (longint'(1) <<< 21)) >>> 22, 32);
      bq_x[b][1] = bq_x[b][0];
      bq_x[b][0] = x;
      bq_y[b][1] = bq_y[b][0];
      bq_y[b][0] = y;
      return y;
   endfunction

   function automatic deess_result_type deess_predict(logic signed [23:0] x_in);
      deess_result_type res;
      longint x, lo, hp, a, c, edb, target, t, e, ip, f, k, lin, y, lvl;
      int p;
      x = longint'(x_in);
      lo = biquad(0, cfg_low_b0, 2 * cfg_low_b0, x);
      hp = biquad(1, cfg_high_b0, -2 * cfg_high_b0, x);

      a = (hp < 0) ? -hp : hp;
      c = (a > envelope) ? cfg_atk : cfg_rel;
      envelope = (c * envelope + ((longint'(1) <<< 24) - c) * a + (longint'(1) <<< 23)) >>> 24;

      if (envelope == 0) begin
         edb = sbd_pkg::DB_FLOOR;
      end else begin
         p = 31;
         while (((envelope >> p) & 1) == 0) p--;
         if (p >= 8) k = (envelope >> (p - 8)) & 255;
         else k = (envelope << (8 - p)) & 255;
         lvl = longint'(p - 23) * 65536 + longint'(log_lut[k]);
         edb = (lvl * sbd_pkg::DB_PER_OCT + (longint'(1) <<< 23)) >>> 24;
      end

      target = 0;
      if (edb > cfg_thr)
         target = -(((edb - cfg_thr) * cfg_ratio + (longint'(1) <<< 15)) >>> 16);

      t = target * 128;
      c = (t < smooth_gain) ? cfg_atk : cfg_rel;
      smooth_gain = (c * smooth_gain + ((longint'(1) <<< 24) - c) * t
                     + (longint'(1) <<< 23)) >>> 24;

      e = (smooth_gain * sbd_pkg::OCT_PER_UNIT + (longint'(1) <<< 15)) >>> 16;
      ip = e >>> 16;
      f = e - ip * 65536;
      k = (ip > 0) ? 0 : -ip;
      lin = longint'(exp_lut[(f >> 8) & 255]);
      lin = (k >= 40) ? 0 : (lin >> k);
      y = sat_w(lo + ((hp * lin + (longint'(1) <<< 29)) >>> 30), 24);

      res.audio = y[23:0];
      res.env_db = edb[16:0];
      res.gain_db = 17'((smooth_gain + 64) >>> 7);
      res.reducing = (target < sbd_pkg::REDUCE_LIMIT);
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH beat %0d %s: got %0d, expected %0d", results_checked, field, got, want);
      err_count++;
   endtask

   // driver: feeds sample and register beats from the stimulus queue
   always @(posedge clock) begin
      stim_op_type op;
      logic nxt_req_v;
      logic nxt_csr_v;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         gap_left = 0;
         idle_since = 0;
         restore_defaults();
      end else begin
         nxt_req_v = req_valid;
         nxt_csr_v = csr_valid;
         if (req_valid && !req_stall) begin
            result_q.push_back(deess_predict(req_audio_in));
            nxt_req_v = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            apply_cfg(csr_index, csr_wdata);
            cfg_writes++;
            nxt_csr_v = 1'b0;
         end
         if (result_q.size() == 0 && !req_valid) idle_since++;
         else idle_since = 0;

         if (gap_left > 0) begin
            gap_left--;
         end else if (!nxt_req_v && !nxt_csr_v && stim_q.size() > 0) begin
            if (stim_q[0].is_cfg) begin
               // hold register writes until the pipeline has drained
               if (idle_since >= DRAIN_CYCLES) begin
                  op = stim_q.pop_front();
                  csr_index <= op.idx;
                  csr_wdata <= op.data;
                  nxt_csr_v = 1'b1;
               end
            end else begin
               op = stim_q.pop_front();
               req_audio_in <= op.data;
               nxt_req_v = 1'b1;
               samples_sent++;
               if ($urandom_range(0, 63) == 0) idle_on = !idle_on;
               if (idle_on && stim_q.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
                  gap_left = $urandom_range(1, 5);
            end
         end
         req_valid <= nxt_req_v;
         csr_valid <= nxt_csr_v;
      end
   end

   // monitor: checks result beats, drives backpressure, runs the watchdog
   always @(posedge clock) begin
      deess_result_type want;
      logic nxt_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               report_mismatch("unexpected result beat", 1, 0);
            end else begin
               want = result_q.pop_front();
               if (rsp_audio_out !== want.audio)
                  report_mismatch("audio_out", rsp_audio_out, want.audio);
               if (rsp_env_db !== want.env_db)
                  report_mismatch("env_db", rsp_env_db, want.env_db);
               if (rsp_gain_db !== want.gain_db)
                  report_mismatch("gain_db", rsp_gain_db, want.gain_db);
               if (rsp_reducing !== want.reducing)
                  report_mismatch("reducing", rsp_reducing, want.reducing);
               results_checked++;
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", result_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
         nxt_stall = 1'b0;
         if (stall_left > 0) begin
            stall_left--;
            nxt_stall = 1'b1;
         end else if (idle_on && stim_q.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            nxt_stall = 1'b1;
         end
         rsp_stall <= nxt_stall;
      end
   end

   task automatic add_sample(logic [23:0] v);
      stim_op_type op;
      op.is_cfg = 1'b0;
      op.idx = '0;
      op.data = v;
      stim_q.push_back(op);
   endtask

   task automatic add_cfg(logic [2:0] idx, logic [23:0] v);
      stim_op_type op;
      op.is_cfg = 1'b1;
      op.idx = idx;
      op.data = v;
      stim_q.push_back(op);
   endtask

   task automatic add_all_cfg(logic [23:0] lb, logic [23:0] hb, logic [23:0] a1,
                              logic [23:0] a2, logic [23:0] thr, logic [23:0] rat,
                              logic [23:0] atk, logic [23:0] rel);
      add_cfg(sbd_pkg::REG_LOW_B0, lb);
      add_cfg(sbd_pkg::REG_HIGH_B0, hb);
      add_cfg(sbd_pkg::REG_POLE_A1, a1);
      add_cfg(sbd_pkg::REG_POLE_A2, a2);
      add_cfg(sbd_pkg::REG_THRESHOLD, thr);
      add_cfg(sbd_pkg::REG_RATIO, rat);
      add_cfg(sbd_pkg::REG_ATTACK, atk);
      add_cfg(sbd_pkg::REG_RELEASE, rel);
   endtask

   function automatic logic [23:0] jitter(longint base, int span);
      return 24'(base + longint'($urandom_range(0, 2 * span)) - span);
   endfunction

   // random program material: noise, sibilant bursts, slow ramps, near silence
   task automatic add_program(int n);
      int style, amp, run;
      logic signed [23:0] v;
      logic signed [23:0] ramp;
      ramp = '0;
      while (n > 0) begin
         style = $urandom_range(0, 9);
         run = $urandom_range(8, 40);
         amp = $urandom_range(1, 8388607);
         for (int i = 0; i < run && n > 0; i++, n--) begin
            case (style)
               0, 1: v = 24'($urandom);
               2, 3, 4: begin
                  v = 24'($urandom_range(0, amp));
                  if (i % 2) v = -v;
               end
               5, 6: begin
                  ramp = ramp + 24'($urandom_range(0, 200000)) - 24'sd100000;
                  v = ramp;
               end
               7: v = (i % 2) ? 24'h800000 : 24'h7FFFFF;
               default: v = 24'($signed($urandom_range(0, 64)) - 32);
            endcase
            add_sample(v);
         end
      end
   endtask

   initial begin
      // defaults out of reset: silence first, then extremes and a sibilant burst
      add_sample(24'h000000);
      add_sample(24'h7FFFFF);
      add_sample(24'h800000);
      for (int i = 0; i < 6; i++) add_sample((i % 2) ? 24'h800000 : 24'h7FFFFF);
      add_sample(24'h000001);
      add_sample(24'hFFFFFF);
      add_sample(24'h000000);
      // deep gain: lowest threshold, steepest slope, instant smoothing
      add_all_cfg(sbd_pkg::RST_LOW_B0, sbd_pkg::RST_HIGH_B0, sbd_pkg::RST_POLE_A1,
                  sbd_pkg::RST_POLE_A2, 24'hFF8800, 24'h00FFFF, 24'h000000, 24'h000000);
      for (int i = 0; i < 4; i++) add_sample((i % 2) ? 24'h800000 : 24'h7FFFFF);
      // unstable poles drive the band outputs into saturation
      add_cfg(sbd_pkg::REG_POLE_A1, 24'h800000);
      add_cfg(sbd_pkg::REG_POLE_A2, 24'h800000);
      for (int i = 0; i < 4; i++) add_sample(24'h7FFFFF);
      // out-of-range threshold, upper data bits set on narrow registers
      add_all_cfg(24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000,
                  24'hAB7FFF, 24'h550000, 24'hFFFFFF, 24'hFFFFFF);
      for (int i = 0; i < 4; i++) add_sample(24'($urandom));

      // random settings sweep: near-default, extreme low, extreme high, random, then wide jitter around the defaults
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: add_all_cfg(jitter(sbd_pkg::RST_LOW_B0, 50000),
                           jitter(sbd_pkg::RST_HIGH_B0, 50000),
                           jitter(sbd_pkg::RST_POLE_A1, 20000),
                           jitter(sbd_pkg::RST_POLE_A2, 20000),
                           24'($signed($urandom_range(0, 30720)) * -1),
                           24'($urandom_range(0, 65535)),
                           24'($urandom_range(14000000, 16777215)),
                           24'($urandom_range(16000000, 16777215)));
            1: add_all_cfg(24'h800000, 24'h800000, 24'h800000, 24'h800000,
                           24'hFF8800, 24'h000000, 24'h000000, 24'h000000);
            2: add_all_cfg(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                           24'h000000, 24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF);
            3: add_all_cfg(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                           24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
            default: add_all_cfg(jitter(sbd_pkg::RST_LOW_B0, 200000),
                                 jitter(sbd_pkg::RST_HIGH_B0, 200000),
                                 jitter(sbd_pkg::RST_POLE_A1, 40000),
                                 jitter(sbd_pkg::RST_POLE_A2, 40000),
                                 24'($signed($urandom_range(0, 30720)) * -1),
                                 24'($urandom_range(0, 65535)),
                                 24'($urandom_range(0, 16777215)),
                                 24'($urandom_range(0, 16777215)));
         endcase
         add_program(ph == 1 || ph == 2 || ph == 3 ? 80 : 250);
      end

      @(negedge reset);
      do @(posedge clock);
      while (stim_q.size() != 0 || req_valid || csr_valid || result_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (result_q.size() != 0)
         report_mismatch("results never arrived", 0, result_q.size());
      $display("Ran %0d samples across %0d register writes, %0d results compared",
               samples_sent, cfg_writes, results_checked);
      $display("Covered silence, full-scale sibilance, deep reduction and unstable poles");
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
